// ===== rtl/core/rdma_qp_round_robin_scheduler_defines.svh =====
// Assertion macros for the scheduler port checker
`ifndef RDMA_QP_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define RDMA_QP_ROUND_ROBIN_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RQRRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, sampled on clk, off during reset
`define RQRRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== rtl/core/rqrrs_pkg.sv =====
// Package: types, codes and helpers of the queue pair scheduler
`timescale 1ns / 1ps
`default_nettype none
package rqrrs_pkg;

    localparam int DEF_MAX_QPS        = 64;
    localparam int DEF_NUM_PRIORITIES = 8;
    localparam logic [2:0] ACK_PRIO_RESET = 3'd3;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SCHED  = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    localparam logic [1:0] GRANT_NONE = 2'd0;
    localparam logic [1:0] GRANT_ACK  = 2'd1;
    localparam logic [1:0] GRANT_QP   = 2'd2;
    localparam logic [1:0] GRANT_ERR  = 2'd3;

    localparam int FLG_BYTES = 3;
    localparam int FLG_WIN   = 4;
    localparam int FLG_GP    = 5;
    localparam int FLG_FIN   = 6;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  qp_index;
        logic [2:0]  qp_priority;
        logic        has_bytes;
        logic        window_bound;
        logic        grant_paused;
        logic        qp_finished;
        logic [63:0] next_avail;
        logic [63:0] now_time;
        logic [7:0]  paused_mask;
        logic        ack_pending;
    } in_t;

    typedef struct packed {
        logic [1:0]  grant_kind;
        logic [5:0]  grant_index;
        logic [6:0]  qp_count;
        logic        wake_valid;
        logic [63:0] wake_time;
    } out_t;

    typedef struct packed {
        logic [6:0]  flags;
        logic [63:0] next_time;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic take_head;
    } cell_ctl_t;

    function automatic logic prio_paused(input logic [2:0] prio, input logic [7:0] mask,
                                         input int num_pri);
        return (int'(prio) < num_pri) && mask[prio];
    endfunction

    function automatic logic qp_eligible(input logic [6:0] flags, input logic [7:0] mask,
                                         input int num_pri);
        return !prio_paused(flags[2:0], mask, num_pri) && !flags[FLG_GP] &&
               flags[FLG_BYTES] && !flags[FLG_WIN];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rdma_qp_round_robin_scheduler.sv =====
// Top level: queue pair send scheduler, a ring of entry cells plus sequencer
//
// Input channel in_valid/in_ready/in_data carries commands: write entry,
// append entry, schedule one send opportunity. Output channel
// out_valid/out_ready/out_data returns exactly one result per command.
// cfg_wr_en/cfg_wr_data load the ack priority class (reset value 3).
// Write, append, error, ack grant and a schedule on an empty table go
// from accept straight to the result state. A schedule that walks the
// table first reduces (last grant + 1) mod count by repeated subtraction;
// then the cell ring rotates once for the round robin scan
// and once more for compaction, one cell step per cycle.
// One command is in work at a time; in_ready is high only while idle.
// The result sits in an output register; a stalled receiver holds it and
// a finished schedule waits for the register to drain, so nothing is lost.
// Reset empties the table, clears the last grant and drops any result.
`timescale 1ns / 1ps
`default_nettype none
module rdma_qp_round_robin_scheduler #(
    parameter int MAX_QPS        = rqrrs_pkg::DEF_MAX_QPS,
    parameter int NUM_PRIORITIES = rqrrs_pkg::DEF_NUM_PRIORITIES
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_wr_en,
    input  wire  [2:0]           cfg_wr_data,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire rqrrs_pkg::in_t  in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output rqrrs_pkg::out_t      out_data
);
    import rqrrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_QPS);

    entry_t           cell_q [MAX_QPS];
    cell_ctl_t        ctl;
    entry_t           load_data;
    logic [IDX_W-1:0] load_idx;
    logic [IDX_W-1:0] target_idx;

    rqrrs_ctrl #(
        .MAX_QPS        (MAX_QPS),
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .head        (cell_q[0]),
        .cell_ctl    (ctl),
        .load_idx    (load_idx),
        .load_data   (load_data),
        .target_idx  (target_idx)
    );

    for (genvar p = 0; p < MAX_QPS; p++)
    begin : g_cell
        cell_ctl_t cctl;
        entry_t    nxt;

        assign cctl.load      = ctl.load && (load_idx == IDX_W'(p));
        assign cctl.shift     = ctl.shift;
        assign cctl.take_head = ctl.take_head && (target_idx == IDX_W'(p));
        assign nxt            = (p == MAX_QPS - 1) ? cell_q[0] : cell_q[(p + 1) % MAX_QPS];

        rqrrs_cell u_cell (
            .clk       (clk),
            .ctl       (cctl),
            .load_data (load_data),
            .head_data (cell_q[0]),
            .next_data (nxt),
            .q         (cell_q[p])
        );
    end

endmodule
`default_nettype wire

// ===== rtl/core/rqrrs_cell.sv =====
// One table cell: holds a queue pair entry, shifts toward the head
`timescale 1ns / 1ps
`default_nettype none
module rqrrs_cell (
    input  wire                        clk,
    input  wire rqrrs_pkg::cell_ctl_t  ctl,
    input  wire rqrrs_pkg::entry_t     load_data,
    input  wire rqrrs_pkg::entry_t     head_data,
    input  wire rqrrs_pkg::entry_t     next_data,
    output rqrrs_pkg::entry_t          q
);
    import rqrrs_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load)
        begin
            entry_next = load_data;
        end
        else if (ctl.shift)
        begin
            // head item lands here when this cell is the write target
            entry_next = ctl.take_head ? head_data : next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rqrrs_ctrl.sv =====
// Sequencer: command decode, round robin scan pass, compaction pass, result
`timescale 1ns / 1ps
`default_nettype none
module rqrrs_ctrl #(
    parameter int MAX_QPS        = rqrrs_pkg::DEF_MAX_QPS,
    parameter int NUM_PRIORITIES = rqrrs_pkg::DEF_NUM_PRIORITIES
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire  [2:0]                       cfg_wr_data,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire rqrrs_pkg::in_t              in_data,
    output logic                             out_valid,
    input  wire                              out_ready,
    output rqrrs_pkg::out_t                  out_data,
    input  wire rqrrs_pkg::entry_t           head,
    output rqrrs_pkg::cell_ctl_t             cell_ctl,
    output logic [$clog2(MAX_QPS)-1:0]       load_idx,
    output rqrrs_pkg::entry_t                load_data,
    output logic [$clog2(MAX_QPS)-1:0]       target_idx
);
    import rqrrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_QPS);
    localparam int CNT_W = $clog2(MAX_QPS + 1);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_QPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_COMPACT,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [2:0]       ackp_reg, ackp_next;
    logic             out_valid_reg, out_valid_next;

    out_t             out_reg, out_next;
    logic [1:0]       kind_reg, kind_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [IDX_W-1:0] t_reg, t_next;
    logic [IDX_W-1:0] dst_reg, dst_next;
    logic [CNT_W-1:0] newcnt_reg, newcnt_next;
    logic [IDX_W-1:0] gnew_reg, gnew_next;
    logic             wake_found_reg, wake_found_next;
    logic [63:0]      wake_t_reg, wake_t_next;
    logic [63:0]      now_reg, now_next;
    logic [7:0]       mask_reg, mask_next;
    logic             a_found_reg, a_found_next, b_found_reg, b_found_next;
    logic             f0_found_reg, f0_found_next, f1_found_reg, f1_found_next;
    logic [IDX_W-1:0] a_reg, a_next, b_reg, b_next, f0_reg, f0_next, f1_reg, f1_next;

    logic             in_tbl, elig, grantable, fincand, keep;
    logic             g_found, fin_found;
    logic [IDX_W-1:0] g_idx, fin_idx;
    logic [IDX_W+5:0] qidx_wide;
    logic [CNT_W+5:0] qidx_cnt;
    logic [IDX_W+5:0] gnew_wide;
    logic [CNT_W+6:0] count_wide;
    logic             wake_ok;

    assign in_tbl    = CNT_W'(t_reg) < count_reg;
    assign elig      = qp_eligible(head.flags, mask_reg, NUM_PRIORITIES);
    assign grantable = elig && (head.next_time <= now_reg);
    assign fincand   = !elig && head.flags[FLG_FIN];

    // grant and first removed entry, from the scan trackers
    assign g_found   = a_found_reg || b_found_reg;
    assign g_idx     = a_found_reg ? a_reg : b_reg;
    assign fin_found = a_found_reg ? f1_found_reg : (f0_found_reg || f1_found_reg);
    assign fin_idx   = a_found_reg ? f1_reg : (f0_found_reg ? f0_reg : f1_reg);

    assign qidx_wide  = {{IDX_W{1'b0}}, in_data.qp_index};
    assign qidx_cnt   = {{CNT_W{1'b0}}, in_data.qp_index};
    assign gnew_wide  = {6'b0, gnew_reg};
    assign count_wide = {7'b0, count_reg};
    assign wake_ok    = wake_found_reg && (wake_t_reg > now_reg);

    assign load_data.flags = {in_data.qp_finished, in_data.grant_paused, in_data.window_bound,
                              in_data.has_bytes, in_data.qp_priority};
    assign load_data.next_time = in_data.next_avail;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        ackp_next       = cfg_wr_en ? cfg_wr_data : ackp_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        kind_next       = kind_reg;
        s_next          = s_reg;
        t_next          = t_reg;
        dst_next        = dst_reg;
        newcnt_next     = newcnt_reg;
        gnew_next       = gnew_reg;
        wake_found_next = wake_found_reg;
        wake_t_next     = wake_t_reg;
        now_next        = now_reg;
        mask_next       = mask_reg;
        a_found_next    = a_found_reg;
        b_found_next    = b_found_reg;
        f0_found_next   = f0_found_reg;
        f1_found_next   = f1_found_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        f0_next         = f0_reg;
        f1_next         = f1_reg;
        cell_ctl        = '0;
        load_idx        = '0;
        target_idx      = LAST_POS;
        keep            = 1'b1;
        in_ready        = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next        = in_data.now_time;
                    mask_next       = in_data.paused_mask;
                    wake_found_next = 1'b0;
                    state_next      = ST_DONE;
                    case (in_data.command)
                        CMD_WRITE:
                        begin
                            if (qidx_cnt < {6'b0, count_reg})
                            begin
                                cell_ctl.load = 1'b1;
                                load_idx      = qidx_wide[IDX_W-1:0];
                                kind_next     = GRANT_NONE;
                            end
                            else
                            begin
                                kind_next = GRANT_ERR;
                            end
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_QPS))
                            begin
                                cell_ctl.load = 1'b1;
                                load_idx      = count_reg[IDX_W-1:0];
                                count_next    = count_reg + CNT_W'(1);
                                kind_next     = GRANT_NONE;
                            end
                            else
                            begin
                                kind_next = GRANT_ERR;
                            end
                        end
                        CMD_SCHED:
                        begin
                            if (in_data.ack_pending &&
                                !prio_paused(ackp_reg, in_data.paused_mask, NUM_PRIORITIES))
                            begin
                                kind_next = GRANT_ACK;
                            end
                            else if (count_reg == '0)
                            begin
                                kind_next = GRANT_NONE;
                            end
                            else
                            begin
                                s_next     = CNT_W'(last_reg) + CNT_W'(1);
                                state_next = ST_MOD;
                            end
                        end
                        default:
                        begin
                            kind_next = GRANT_ERR;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                // scan start = (last + 1) mod count, one subtract per cycle
                if (s_reg >= count_reg)
                begin
                    s_next = s_reg - count_reg;
                end
                else
                begin
                    state_next    = ST_SCAN;
                    t_next        = '0;
                    a_found_next  = 1'b0;
                    b_found_next  = 1'b0;
                    f0_found_next = 1'b0;
                    f1_found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // full rotation, head entry t goes back to the tail
                cell_ctl.shift     = 1'b1;
                cell_ctl.take_head = 1'b1;
                if (in_tbl)
                begin
                    if (CNT_W'(t_reg) >= s_reg)
                    begin
                        if (grantable && !a_found_reg)
                        begin
                            a_found_next = 1'b1;
                            a_next       = t_reg;
                        end
                        if (fincand && !a_found_reg && !f1_found_reg)
                        begin
                            f1_found_next = 1'b1;
                            f1_next       = t_reg;
                        end
                    end
                    else
                    begin
                        if (grantable && !b_found_reg)
                        begin
                            b_found_next = 1'b1;
                            b_next       = t_reg;
                        end
                        if (fincand && !b_found_reg && !f0_found_reg)
                        begin
                            f0_found_next = 1'b1;
                            f0_next       = t_reg;
                        end
                    end
                end
                if (t_reg == LAST_POS)
                begin
                    state_next  = ST_COMPACT;
                    t_next      = '0;
                    dst_next    = '0;
                    newcnt_next = '0;
                    wake_found_next = 1'b0;
                end
                else
                begin
                    t_next = t_reg + IDX_W'(1);
                end
            end
            ST_COMPACT:
            begin
                // kept entry lands where it ends up at dst after the rotation
                keep = !(fin_found && in_tbl &&
                         ((t_reg == fin_idx) || ((t_reg > fin_idx) && head.flags[FLG_FIN])));
                cell_ctl.shift     = 1'b1;
                cell_ctl.take_head = keep;
                target_idx         = dst_reg + LAST_POS - t_reg;
                if (t_reg == '0)
                begin
                    gnew_next = g_idx;
                end
                if (keep)
                begin
                    dst_next = dst_reg + IDX_W'(1);
                    if (g_found && (t_reg == g_idx))
                    begin
                        gnew_next = dst_reg;
                    end
                    if (in_tbl)
                    begin
                        newcnt_next = newcnt_reg + CNT_W'(1);
                        if (head.flags[FLG_BYTES] && !head.flags[FLG_GP] &&
                            (!wake_found_reg || (head.next_time < wake_t_reg)))
                        begin
                            wake_found_next = 1'b1;
                            wake_t_next     = head.next_time;
                        end
                    end
                end
                if (t_reg == LAST_POS)
                begin
                    count_next = newcnt_next;
                    if (g_found)
                    begin
                        last_next = gnew_next;
                    end
                    kind_next  = g_found ? GRANT_QP : GRANT_NONE;
                    state_next = ST_DONE;
                end
                else
                begin
                    t_next = t_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.grant_kind  = kind_reg;
                    out_next.grant_index = (kind_reg == GRANT_QP) ? gnew_wide[5:0] : 6'd0;
                    out_next.qp_count    = count_wide[6:0];
                    out_next.wake_valid  = (kind_reg == GRANT_NONE) && wake_ok;
                    out_next.wake_time   = ((kind_reg == GRANT_NONE) && wake_ok) ?
                                           wake_t_reg : 64'd0;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_reg      <= '0;
            ackp_reg      <= ACK_PRIO_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            ackp_reg      <= ackp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg        <= out_next;
        kind_reg       <= kind_next;
        s_reg          <= s_next;
        t_reg          <= t_next;
        dst_reg        <= dst_next;
        newcnt_reg     <= newcnt_next;
        gnew_reg       <= gnew_next;
        wake_found_reg <= wake_found_next;
        wake_t_reg     <= wake_t_next;
        now_reg        <= now_next;
        mask_reg       <= mask_next;
        a_found_reg    <= a_found_next;
        b_found_reg    <= b_found_next;
        f0_found_reg   <= f0_found_next;
        f1_found_reg   <= f1_found_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        f0_reg         <= f0_next;
        f1_reg         <= f1_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rqrrs_checker.sv =====
// Port checker for the scheduler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "rdma_qp_round_robin_scheduler_defines.svh"
module rqrrs_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   in_valid,
    input wire                   in_ready,
    input wire                   out_valid,
    input wire                   out_ready,
    input wire rqrrs_pkg::out_t  out_data
);
    import rqrrs_pkg::*;

    `RQRRS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `RQRRS_ASSERT_NXT(a_one_in_work, in_valid && in_ready, !in_ready)
    `RQRRS_ASSERT_IMP(a_index_only_qp, out_valid && (out_data.grant_kind != GRANT_QP), out_data.grant_index == 6'd0)
    `RQRRS_ASSERT_IMP(a_wake_only_none, out_valid && out_data.wake_valid, out_data.grant_kind == GRANT_NONE)
    `RQRRS_ASSERT_IMP(a_wake_zero, out_valid && !out_data.wake_valid, out_data.wake_time == 64'd0)

endmodule

bind rdma_qp_round_robin_scheduler rqrrs_checker u_rqrrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

// ===== sim/qp_sched_checker.sv =====
// Checker: predicts scheduler results and compares them with the output channel
`timescale 1ns / 1ps
module qp_sched_checker (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_wr_en,
    input  wire  [2:0]       cfg_wr_data,
    input  wire              in_valid,
    input  wire              in_ready,
    input  rqrrs_pkg::in_t   in_data,
    input  wire              out_valid,
    input  wire              out_ready,
    input  rqrrs_pkg::out_t  out_data,
    output int               errors,
    output int               pending
);
    import rqrrs_pkg::*;

    localparam int NQ = 64;
    localparam int NPRI = 8;

    logic [6:0]  tbl_flags [NQ];
    logic [63:0] tbl_time [NQ];
    int          tbl_count;
    int          last_grant;
    logic [2:0]  ack_class;
    out_t        results_due [$];

    function automatic bit class_paused(logic [2:0] p, logic [7:0] mask);
        return (int'(p) < NPRI) && mask[p];
    endfunction

    function automatic out_t schedule_result(in_t c);
        out_t r;
        int n, idx, grant, min_fin, dst;
        bit got, fin_seen, found, ok;
        logic [6:0] f;
        logic [63:0] t;
        r = '0;
        if (c.command == CMD_WRITE) begin
            if (int'(c.qp_index) >= tbl_count) r.grant_kind = GRANT_ERR;
            else begin
                tbl_flags[c.qp_index] = {c.qp_finished, c.grant_paused, c.window_bound,
                                         c.has_bytes, c.qp_priority};
                tbl_time[c.qp_index] = c.next_avail;
            end
        end else if (c.command == CMD_APPEND) begin
            if (tbl_count >= NQ) r.grant_kind = GRANT_ERR;
            else begin
                tbl_flags[tbl_count] = {c.qp_finished, c.grant_paused, c.window_bound,
                                        c.has_bytes, c.qp_priority};
                tbl_time[tbl_count] = c.next_avail;
                tbl_count++;
            end
        end else if (c.command != CMD_SCHED) begin
            r.grant_kind = GRANT_ERR;
        end else if (c.ack_pending && !class_paused(ack_class, c.paused_mask)) begin
            r.grant_kind = GRANT_ACK;
        end else begin
            n = tbl_count;
            got = 0; fin_seen = 0; grant = 0; min_fin = 0;
            for (int k = 1; k <= n && !got; k++) begin
                idx = (k + last_grant) % n;
                f = tbl_flags[idx];
                ok = !class_paused(f[2:0], c.paused_mask) && !f[FLG_GP] && f[FLG_BYTES]
                     && !f[FLG_WIN];
                if (ok) begin
                    if (tbl_time[idx] <= c.now_time) begin
                        grant = idx;
                        got = 1;
                    end
                end else if (f[FLG_FIN]) begin
                    if (!fin_seen || idx < min_fin) min_fin = idx;
                    fin_seen = 1;
                end
            end
            if (fin_seen) begin
                dst = min_fin;
                for (int i = min_fin + 1; i < n; i++) begin
                    if (!tbl_flags[i][FLG_FIN]) begin
                        if (got && i == grant) grant = dst;
                        tbl_flags[dst] = tbl_flags[i];
                        tbl_time[dst] = tbl_time[i];
                        dst++;
                    end
                end
                tbl_count = dst;
            end
            if (got) begin
                last_grant = grant;
                r.grant_kind = GRANT_QP;
                r.grant_index = grant[5:0];
            end else begin
                found = 0; t = '0;
                for (int i = 0; i < tbl_count; i++) begin
                    f = tbl_flags[i];
                    if (f[FLG_BYTES] && !f[FLG_GP]) begin
                        if (!found || tbl_time[i] < t) t = tbl_time[i];
                        found = 1;
                    end
                end
                if (found && t > c.now_time) begin
                    r.wake_valid = 1'b1;
                    r.wake_time = t;
                end
            end
        end
        r.qp_count = tbl_count[6:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n) begin
            tbl_count = 0;
            last_grant = 0;
            ack_class = ACK_PRIO_RESET;
            results_due.delete();
            errors = 0;
            pending = 0;
        end else begin
            // output side first: a result never belongs to an item taken this edge
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, out_data);
                end else begin
                    want = results_due.pop_front();
                    if (out_data.grant_kind !== want.grant_kind ||
                        out_data.grant_index !== want.grant_index ||
                        out_data.qp_count !== want.qp_count ||
                        out_data.wake_valid !== want.wake_valid ||
                        out_data.wake_time !== want.wake_time) begin
                        errors++;
                        $display("%0t: mismatch expected %h actual %h",
                                 $time, want, out_data);
                    end
                end
            end
            if (in_valid && in_ready)
                results_due.insert(results_due.size(), schedule_result(in_data));
            if (cfg_wr_en) ack_class = cfg_wr_data;
            pending = results_due.size();
        end
    end
endmodule

// ===== sim/tb_top.sv =====
// Testbench top: stimulus, handshake pacing and verdict for the QP scheduler
`timescale 1ns / 1ps
module tb_top;
    import rqrrs_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [2:0] cfg_wr_data;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    int   errors;
    int   pending;
    int   idle_cycles;
    bit   hold_rx;
    int   model_count;

    rdma_qp_round_robin_scheduler i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    qp_sched_checker i_chk (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        bit hold_done;
        int g;
        hold_done = 0;
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_rx && !hold_done)
            begin
                out_ready <= 0;
                repeat (400) @(posedge clk);
                hold_done = 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                g = gap_len();
                if (g > 0)
                begin
                    out_ready <= 0;
                    repeat (g) @(posedge clk);
                end
            end
            out_ready <= 1;
        end
    end

    // watchdog: cycles with nothing accepted
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("rdma_qp_round_robin_scheduler regression: fail");
            $finish;
        end
    end

    // valid stays up into the next item when the gap after this one is empty
    task automatic send_item(in_t c);
        int g;
        in_valid <= 1;
        in_data <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_ack_class(logic [2:0] v);
        drain();
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
    endtask

    function automatic in_t make_cmd(logic [1:0] op, int cnt, bit wellformed);
        in_t c;
        c = '0;
        c.command = op;
        c.qp_priority = 3'($urandom_range(0, 7));
        c.has_bytes = $urandom_range(0, 4) != 0;
        c.window_bound = $urandom_range(0, 4) == 0;
        c.grant_paused = $urandom_range(0, 5) == 0;
        c.qp_finished = $urandom_range(0, 6) == 0;
        c.now_time = {32'h0, $urandom_range(0, 2000)};
        c.next_avail = {32'h0, $urandom_range(0, 2000)};
        if ($urandom_range(0, 15) == 0) c.next_avail = rand64();
        if ($urandom_range(0, 15) == 0) c.now_time = rand64();
        c.paused_mask = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        c.ack_pending = $urandom_range(0, 3) == 0;
        if (wellformed && cnt > 0) c.qp_index = 6'($urandom_range(0, cnt - 1));
        else c.qp_index = 6'($urandom_range(0, 63));
        return c;
    endfunction

    initial
    begin
        in_t c;
        int op;
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        in_valid = 0;
        in_data = '0;
        hold_rx = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty table, errors, extremes, ack
        c = '0; c.command = CMD_SCHED; send_item(c);
        c = '0; c.command = CMD_WRITE; c.qp_index = 6'd63; send_item(c);
        c = '0; c.command = CMD_RSVD; send_item(c);
        c = '1; c.command = CMD_APPEND; send_item(c);
        c = '0; c.command = CMD_APPEND; c.has_bytes = 1; c.next_avail = '1; send_item(c);
        c = '0; c.command = CMD_APPEND; c.has_bytes = 1; c.qp_priority = 3'd7; send_item(c);
        c = '0; c.command = CMD_WRITE; c.qp_index = 6'd0; c.has_bytes = 1;
        c.qp_finished = 1; send_item(c);
        c = '0; c.command = CMD_SCHED; c.ack_pending = 1; send_item(c);
        c = '0; c.command = CMD_SCHED; c.ack_pending = 1; c.paused_mask = 8'h08; send_item(c);
        c = '0; c.command = CMD_SCHED; c.paused_mask = 8'hff; send_item(c);
        c = '0; c.command = CMD_SCHED; send_item(c);
        c = '0; c.command = CMD_SCHED; c.now_time = '1; send_item(c);
        c = '1; c.command = CMD_SCHED; c.ack_pending = 0; send_item(c);
        // fill the table to force the full-table error
        for (int i = 0; i < 66; i++) begin
            c = make_cmd(CMD_APPEND, 0, 0);
            c.qp_finished = 0;
            send_item(c);
        end
        c = '0; c.command = CMD_SCHED; c.now_time = '1; send_item(c);
        c = '0; c.command = CMD_SCHED; c.now_time = '1; send_item(c);

        // long receiver hold-off while items keep coming
        hold_rx = 1;
        for (int i = 0; i < 6; i++) send_item(make_cmd(CMD_WRITE, 64, 1));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_ack_class(3'd0);
                1: set_ack_class(3'd7);
                2: set_ack_class(3'($urandom_range(0, 7)));
                default: set_ack_class(3'd3);
            endcase
            for (int i = 0; i < 130; i++) begin
                op = $urandom_range(0, 99);
                model_count = i_chk.tbl_count;
                if (op < 30) c = make_cmd(CMD_APPEND, model_count, 1);
                else if (op < 50) c = make_cmd(CMD_WRITE, model_count, op < 47);
                else if (op < 97) c = make_cmd(CMD_SCHED, model_count, 1);
                else c = make_cmd(CMD_RSVD, model_count, 1);
                send_item(c);
            end
        end
        drain();

        if (errors == 0 && pending == 0)
            $display("rdma_qp_round_robin_scheduler regression: pass");
        else
            $display("rdma_qp_round_robin_scheduler regression: fail");
        $finish;
    end
endmodule
